/* hdl/ssmt_pkg.sv */
package ssmt_pkg;

    localparam int SLOT_COUNT_DEF = 16;

    localparam int KIND_W   = 3;
    localparam int CHAN_W   = 6;
    localparam int OWNER_W  = 6;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 6;

    // free-slot search examines this many slots per cycle
    localparam int GROUP   = 8;
    localparam int GROUP_W = 3;

    localparam logic [KIND_W-1:0] K_CREATE  = 3'd0;
    localparam logic [KIND_W-1:0] K_PUT     = 3'd1;
    localparam logic [KIND_W-1:0] K_TAKE    = 3'd2;
    localparam logic [KIND_W-1:0] K_DESTROY = 3'd3;
    localparam logic [KIND_W-1:0] K_CLEANUP = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ERR   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BLOCK = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic latch;
        logic exec;
        logic scan_init;
        logic scan;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic is_create;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

/* hdl/ssmt_ram.sv */
module ssmt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/ssmt_ctrl.sv */
module ssmt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ssmt_pkg::t_sts i_sts,
    output logic           o_ready,
    output ssmt_pkg::t_cmd o_cmd
);
    import ssmt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = i_sts.is_create ? S_SCAN : S_RESULT;
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.latch = i_valid;
            end
            S_DECODE: begin
                o_cmd.exec      = !i_sts.is_create;
                o_cmd.scan_init = i_sts.is_create;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_RESULT: begin
                o_cmd.load = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

/* hdl/ssmt_dp.sv */
module ssmt_dp #(
    parameter int SLOT_COUNT = ssmt_pkg::SLOT_COUNT_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ssmt_pkg::t_cmd                        i_cmd,
    output ssmt_pkg::t_sts                        o_sts,
    input  logic [ssmt_pkg::KIND_W-1:0]           i_kind,
    input  logic [ssmt_pkg::CHAN_W-1:0]           i_channel,
    input  logic [ssmt_pkg::OWNER_W-1:0]          i_owner,
    input  logic signed [ssmt_pkg::DATA_W-1:0]    i_data_in,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [ssmt_pkg::STATUS_W-1:0]         o_status,
    output logic [ssmt_pkg::INDEX_W-1:0]          o_slot_index,
    output logic signed [ssmt_pkg::DATA_W-1:0]    o_data_out
);
    import ssmt_pkg::*;

    localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int NGROUP = (SLOT_COUNT + GROUP - 1) / GROUP;
    localparam int GW     = (NGROUP > 1) ? $clog2(NGROUP) : 1;
    localparam int PAD    = NGROUP * GROUP;

    // latched request
    logic [KIND_W-1:0]  r_kind;
    logic [CHAN_W-1:0]  r_chan;
    logic [OWNER_W-1:0] r_owner;
    logic [DATA_W-1:0]  r_data;

    // slot table
    logic [SLOT_COUNT-1:0] r_valid, n_valid;
    logic [SLOT_COUNT-1:0] r_full, n_full;
    logic [OWNER_W-1:0]    r_own [SLOT_COUNT];
    logic [OWNER_W-1:0]    n_own [SLOT_COUNT];

    // result being built
    logic [STATUS_W-1:0] r_status, n_status;
    logic [INDEX_W-1:0]  r_index, n_index;
    logic                r_take, n_take;
    logic [GW-1:0]       r_grp, n_grp;

    // output register
    logic                r_o_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [INDEX_W-1:0]  r_o_index;
    logic [DATA_W-1:0]   r_o_data;

    logic [IDX_W-1:0]    w_ci;
    logic                w_chan_ok;
    logic                w_usable;
    logic [PAD-1:0]      w_taken;
    logic [GROUP-1:0]    w_bits;
    logic [GROUP_W-1:0]  w_sel;
    logic                w_found;
    logic                w_last;
    logic [GW+GROUP_W-1:0] w_claim;
    logic                w_ram_we;
    logic [DATA_W-1:0]   w_ram_q;
    logic                w_out_free;

    assign w_ci      = r_chan[IDX_W-1:0];
    assign w_chan_ok = ({1'b0, r_chan} < (CHAN_W + 1)'(SLOT_COUNT));
    assign w_usable  = w_chan_ok && r_valid[w_ci];

    // slots past the table end count as taken
    always_comb begin
        w_taken = '1;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            w_taken[k] = r_valid[k];
        end
    end

    assign w_bits = w_taken[{r_grp, {GROUP_W{1'b0}}} +: GROUP];

    always_comb begin
        w_sel = '0;
        for (int j = GROUP - 1; j >= 0; j--) begin
            if (!w_bits[j]) begin
                w_sel = GROUP_W'(j);
            end
        end
    end

    assign w_found = !(&w_bits);
    assign w_last  = (r_grp == GW'(NGROUP - 1));
    assign w_claim = {r_grp, w_sel};

    assign w_out_free = !r_o_valid || i_ready;

    assign o_sts.is_create = (r_kind == K_CREATE);
    assign o_sts.scan_done = w_found || w_last;
    assign o_sts.out_free  = w_out_free;

    always_comb begin
        n_valid  = r_valid;
        n_full   = r_full;
        n_own    = r_own;
        n_status = r_status;
        n_index  = r_index;
        n_take   = r_take;
        n_grp    = r_grp;
        w_ram_we = 1'b0;

        if (i_cmd.exec) begin
            n_status = ST_ERR;
            n_index  = '0;
            n_take   = 1'b0;
            unique case (r_kind)
                K_PUT: begin
                    if (w_usable) begin
                        if (r_full[w_ci]) begin
                            n_status = ST_BLOCK;
                        end else begin
                            w_ram_we     = 1'b1;
                            n_full[w_ci] = 1'b1;
                            n_status     = ST_OK;
                        end
                    end
                end
                K_TAKE: begin
                    if (w_usable) begin
                        if (!r_full[w_ci]) begin
                            n_status = ST_BLOCK;
                        end else begin
                            n_full[w_ci] = 1'b0;
                            n_take       = 1'b1;
                            n_status     = ST_OK;
                        end
                    end
                end
                K_DESTROY: begin
                    if (w_usable) begin
                        n_valid[w_ci] = 1'b0;
                        n_status      = ST_OK;
                    end
                end
                K_CLEANUP: begin
                    for (int k = 0; k < SLOT_COUNT; k++) begin
                        if (r_valid[k] && (r_own[k] == r_owner)) begin
                            n_valid[k] = 1'b0;
                        end
                    end
                    n_status = ST_OK;
                end
                default: ;
            endcase
        end

        if (i_cmd.scan_init) begin
            n_grp = '0;
        end

        if (i_cmd.scan) begin
            n_take = 1'b0;
            n_grp  = r_grp + 1'b1;
            if (w_found) begin
                n_valid[w_claim[IDX_W-1:0]] = 1'b1;
                n_own[w_claim[IDX_W-1:0]]   = r_owner;
                n_status = ST_OK;
                n_index  = INDEX_W'(w_claim);
            end else if (w_last) begin
                n_status = ST_ERR;
                n_index  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_full    <= '0;
            r_own     <= '{default: '0};
            r_o_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_full  <= n_full;
            r_own   <= n_own;
            if (i_cmd.load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind  <= i_kind;
            r_chan  <= i_channel;
            r_owner <= i_owner;
            r_data  <= i_data_in;
        end
        r_status <= n_status;
        r_index  <= n_index;
        r_take   <= n_take;
        r_grp    <= n_grp;
        if (i_cmd.load) begin
            r_o_status <= r_status;
            r_o_index  <= r_index;
            r_o_data   <= r_take ? w_ram_q : '0;
        end
    end

    // the read address holds the request's slot, so the word is ready at result time
    ssmt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SLOT_COUNT),
        .AW    (IDX_W)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ci),
        .i_wdata (r_data),
        .i_raddr (w_ci),
        .o_rdata (w_ram_q)
    );

    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_slot_index = r_o_index;
    assign o_data_out   = r_o_data;

endmodule

/* hdl/single_slot_mailbox_table.sv */
// Put, take, destroy, cleanup and unused kinds go from decode straight to the result state;
// create first searches the slots one group of 8 at a time, until it finds a free slot or
// has searched the last group. The next item is taken the cycle after the result is loaded
// into the output register, one item at a time; the result waits while that register is full.
// Reset clears every slot's valid, full and owner field; the word store is not
// cleared and no item is refused after reset.
module single_slot_mailbox_table #(
    parameter int SLOT_COUNT = ssmt_pkg::SLOT_COUNT_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [ssmt_pkg::KIND_W-1:0]           i_kind,
    input  logic [ssmt_pkg::CHAN_W-1:0]           i_channel,
    input  logic [ssmt_pkg::OWNER_W-1:0]          i_owner,
    input  logic signed [ssmt_pkg::DATA_W-1:0]    i_data_in,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [ssmt_pkg::STATUS_W-1:0]         o_status,
    output logic [ssmt_pkg::INDEX_W-1:0]          o_slot_index,
    output logic signed [ssmt_pkg::DATA_W-1:0]    o_data_out
);
    import ssmt_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    ssmt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_ready (o_ready),
        .o_cmd   (w_cmd)
    );

    ssmt_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_kind       (i_kind),
        .i_channel    (i_channel),
        .i_owner      (i_owner),
        .i_data_in    (i_data_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_slot_index (o_slot_index),
        .o_data_out   (o_data_out)
    );

endmodule

/* sim/ssmt_reply_checker.sv */
module ssmt_reply_checker #(
    parameter int SLOT_COUNT = ssmt_pkg::SLOT_COUNT_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_req_valid,
    input  logic                                 i_req_ready,
    input  logic [ssmt_pkg::KIND_W-1:0]          i_kind,
    input  logic [ssmt_pkg::CHAN_W-1:0]          i_channel,
    input  logic [ssmt_pkg::OWNER_W-1:0]         i_owner,
    input  logic signed [ssmt_pkg::DATA_W-1:0]   i_data_in,
    input  logic                                 i_rsp_valid,
    input  logic                                 i_rsp_ready,
    input  logic [ssmt_pkg::STATUS_W-1:0]        i_status,
    input  logic [ssmt_pkg::INDEX_W-1:0]         i_slot_index,
    input  logic signed [ssmt_pkg::DATA_W-1:0]   i_data_out,
    output int                                   o_errors,
    output int                                   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import ssmt_pkg::*;

    localparam int PRINT_CAP = 100;

    typedef struct packed {
        logic [STATUS_W-1:0]        status;
        logic [INDEX_W-1:0]         slot_index;
        logic signed [DATA_W-1:0]   data_out;
    } t_reply;

    logic                       box_valid [SLOT_COUNT];
    logic                       box_full  [SLOT_COUNT];
    logic [OWNER_W-1:0]         box_owner [SLOT_COUNT];
    logic signed [DATA_W-1:0]   box_word  [SLOT_COUNT];

    t_reply replies_due [$];
    int     errors = 0;

    assign o_errors = errors;

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        // keep the log short when the block is badly broken
        if (errors < PRINT_CAP)
            $display("%0t: %s mismatch, expected %0h got %0h", $realtime, what, want, got);
        errors++;
    endtask

    // applies one request to the mailbox table and returns its reply
    function automatic t_reply serve_request(input logic [KIND_W-1:0] kind,
                                             input logic [CHAN_W-1:0] ch,
                                             input logic [OWNER_W-1:0] who,
                                             input logic signed [DATA_W-1:0] word);
        t_reply r;
        logic   hit;
        logic   found;
        r = '{status: ST_ERR, slot_index: '0, data_out: '0};
        hit = (int'(ch) < SLOT_COUNT) && box_valid[ch];
        found = 1'b0;
        case (kind)
            K_CREATE: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (!found && !box_valid[i]) begin
                        found = 1'b1;
                        box_valid[i] = 1'b1;
                        box_owner[i] = who;
                        r.status = ST_OK;
                        r.slot_index = INDEX_W'(i);
                    end
                end
            end
            K_PUT: begin
                if (hit) begin
                    if (box_full[ch]) begin
                        r.status = ST_BLOCK;
                    end else begin
                        box_word[ch] = word;
                        box_full[ch] = 1'b1;
                        r.status = ST_OK;
                    end
                end
            end
            K_TAKE: begin
                if (hit) begin
                    if (!box_full[ch]) begin
                        r.status = ST_BLOCK;
                    end else begin
                        r.data_out = box_word[ch];
                        box_full[ch] = 1'b0;
                        r.status = ST_OK;
                    end
                end
            end
            K_DESTROY: begin
                // full flag and word stay behind for the next owner
                if (hit) begin
                    box_valid[ch] = 1'b0;
                    r.status = ST_OK;
                end
            end
            K_CLEANUP: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (box_valid[i] && box_owner[i] == who)
                        box_valid[i] = 1'b0;
                end
                r.status = ST_OK;
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_reply want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                box_valid[i] = 1'b0;
                box_full[i]  = 1'b0;
                box_owner[i] = '0;
            end
            replies_due.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (replies_due.size() == 0) begin
                    report_mismatch("unrequested item, status", '0, i_status);
                end else begin
                    want = replies_due.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", want.status, i_status);
                    if (i_slot_index !== want.slot_index)
                        report_mismatch("slot_index", want.slot_index, i_slot_index);
                    if (i_data_out !== want.data_out)
                        report_mismatch("data_out", want.data_out, i_data_out);
                end
            end
            if (i_req_valid && i_req_ready)
                replies_due.push_back(serve_request(i_kind, i_channel, i_owner, i_data_in));
        end
        o_outstanding <= replies_due.size();
    end

endmodule

/* sim/single_slot_mailbox_table_tb.sv */
module single_slot_mailbox_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ssmt_pkg::*;

    localparam int                SLOTS        = SLOT_COUNT_DEF;
    localparam int                RANDOM_ITEMS = 1430;
    localparam int                HOLD_CYCLES  = 300;
    localparam int                HOLD_AT      = 300;
    localparam int                STEADY_FROM  = 800;
    localparam int                STEADY_TO    = 1000;
    localparam int                DRAIN_CYCLES = 12;
    localparam int                CYCLE_LIMIT  = 200000;
    localparam logic [KIND_W-1:0] K_MAX        = '1;
    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fffffff;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh80000000;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       req_valid;
    logic                       req_ready;
    logic [KIND_W-1:0]          kind;
    logic [CHAN_W-1:0]          channel;
    logic [OWNER_W-1:0]         owner;
    logic signed [DATA_W-1:0]   data_in;
    logic                       rsp_valid;
    logic                       rsp_ready;
    logic [STATUS_W-1:0]        status;
    logic [INDEX_W-1:0]         slot_index;
    logic signed [DATA_W-1:0]   data_out;

    logic hold_req = 1'b0;
    logic steady   = 1'b0;
    int   errors;
    int   outstanding;
    int   cycles = 0;

    always #1 clk = ~clk;

    single_slot_mailbox_table #(
        .SLOT_COUNT(SLOTS)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (req_valid),
        .o_ready     (req_ready),
        .i_kind      (kind),
        .i_channel   (channel),
        .i_owner     (owner),
        .i_data_in   (data_in),
        .o_valid     (rsp_valid),
        .i_ready     (rsp_ready),
        .o_status    (status),
        .o_slot_index(slot_index),
        .o_data_out  (data_out)
    );

    ssmt_reply_checker #(
        .SLOT_COUNT(SLOTS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_kind       (kind),
        .i_channel    (channel),
        .i_owner      (owner),
        .i_data_in    (data_in),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_ready  (rsp_ready),
        .i_status     (status),
        .i_slot_index (slot_index),
        .i_data_out   (data_out),
        .o_errors     (errors),
        .o_outstanding(outstanding)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_item(input logic [KIND_W-1:0] k, input logic [CHAN_W-1:0] ch,
                             input logic [OWNER_W-1:0] who,
                             input logic signed [DATA_W-1:0] word);
        req_valid <= 1'b1;
        kind      <= k;
        channel   <= ch;
        owner     <= who;
        data_in   <= word;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
    endtask

    // mix 0 is balanced, mix 1 fills the table, mix 2 drains it
    task automatic send_random(input int mix);
        int                  roll;
        int                  create_w;
        int                  destroy_w;
        int                  cleanup_w;
        int                  io_w;
        logic [KIND_W-1:0]   k;
        logic [CHAN_W-1:0]   ch;
        logic [OWNER_W-1:0]  who;
        case (mix)
            1:       begin create_w = 35; destroy_w = 5;  cleanup_w = 2;  end
            2:       begin create_w = 8;  destroy_w = 25; cleanup_w = 15; end
            default: begin create_w = 15; destroy_w = 10; cleanup_w = 7;  end
        endcase
        io_w = (92 - create_w - destroy_w - cleanup_w) / 2;
        roll = $urandom_range(0, 99);
        if (roll < create_w)
            k = K_CREATE;
        else if (roll < create_w + io_w)
            k = K_PUT;
        else if (roll < create_w + 2 * io_w)
            k = K_TAKE;
        else if (roll < create_w + 2 * io_w + destroy_w)
            k = K_DESTROY;
        else if (roll < 92)
            k = K_CLEANUP;
        else
            k = KIND_W'($urandom_range(K_CLEANUP + 1, K_MAX));
        // mostly real slots and a few owners, so slots get shared and cleaned up
        if ($urandom_range(0, 9) == 0)
            ch = CHAN_W'($urandom_range(0, (1 << CHAN_W) - 1));
        else
            ch = CHAN_W'($urandom_range(0, SLOTS - 1));
        if ($urandom_range(0, 6) == 0)
            who = OWNER_W'($urandom_range(0, (1 << OWNER_W) - 1));
        else
            who = OWNER_W'($urandom_range(0, 3));
        send_item(k, ch, who, $urandom());
    endtask

    initial begin : stim
        int sent;
        int burst;
        int mix;
        req_valid = 1'b0;
        kind      = K_CREATE;
        channel   = '0;
        owner     = '0;
        data_in   = '0;
        rst_n     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(K_TAKE, '0, '0, '0);              // slot never created
        send_item(K_PUT, '1, '1, -1);               // channel far out of range
        send_item(K_DESTROY, CHAN_W'(SLOTS), '0, '0);
        for (int kk = K_CLEANUP + 1; kk <= K_MAX; kk++)
            send_item(KIND_W'(kk), '0, '0, '0);
        send_item(K_CLEANUP, '0, '1, '0);           // owner holds nothing
        send_item(K_CREATE, '0, '1, '0);
        send_item(K_CREATE, '0, '0, '0);
        send_item(K_TAKE, 6'd0, '0, '0);            // empty, would block
        send_item(K_PUT, 6'd0, '0, WORD_MAX);
        send_item(K_PUT, 6'd0, '0, 32'sd1);         // full, would block
        send_item(K_PUT, 6'd1, '0, WORD_MIN);
        send_item(K_TAKE, 6'd0, '0, '0);
        send_item(K_DESTROY, 6'd1, '0, '0);
        send_item(K_PUT, 6'd1, '0, '0);             // destroyed slot
        send_item(K_CREATE, '0, 6'd5, '0);          // reclaims slot 1, word still there
        send_item(K_TAKE, 6'd1, '0, '0);
        send_item(K_CLEANUP, '0, 6'd5, '0);
        send_item(K_CLEANUP, '0, '1, '0);
        send_item(K_DESTROY, CHAN_W'(SLOTS - 1), '0, '0);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 16);
            mix = $urandom_range(0, 2);
            for (int n = 0; n < burst && sent < RANDOM_ITEMS; n++) begin
                send_random(mix);
                sent++;
                if (sent == HOLD_AT)
                    hold_req <= 1'b1;
            end
            // also drops back to zero once the last item is sent
            steady <= (sent >= STEADY_FROM && sent < STEADY_TO);
            if (!(sent >= STEADY_FROM && sent < STEADY_TO) && $urandom_range(0, 3) != 0) begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        req_valid <= 1'b0;

        // outstanding is registered, so it lags the queue
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin : drain_side
        logic held;
        held = 1'b0;
        rsp_ready = 1'b0;
        @(posedge clk);
        forever begin
            if (steady) begin
                rsp_ready <= 1'b1;
                @(posedge clk);
            end else if (hold_req && !held) begin
                // long hold-off so the block backs up and refuses items
                held = 1'b1;
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                rsp_ready <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                if ($urandom_range(0, 1) != 0) begin
                    rsp_ready <= 1'b0;
                    repeat ($urandom_range(1, 5)) @(posedge clk);
                end
            end
        end
    end

endmodule
